// ----- rtl/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the wheel odometry block
// Fixed-point formats, bit-serial unit widths, arctangent table and helpers.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int MAX_GAP_MS      = 1000;
    localparam int TRIG_ITERATIONS = 24;

    // register file
    localparam int RAD_W  = 20;
    localparam int PP_W   = 7;
    localparam int BASE_W = 22;
    localparam int CFG_W  = 22;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_WHEEL_RADIUS = 3'd0;
    localparam logic [IDX_W-1:0] REG_POLE_PAIRS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEFT_REV     = 3'd2;
    localparam logic [IDX_W-1:0] REG_RIGHT_REV    = 3'd3;
    localparam logic [IDX_W-1:0] REG_WHEEL_BASE   = 3'd4;
    // indexes beyond the register list, writes to them are ignored
    localparam logic [IDX_W-1:0] REG_SPARE_0      = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_1      = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_2      = 3'd7;

    localparam logic [RAD_W-1:0]  RADIUS_RESET = 20'd100000;
    localparam logic [PP_W-1:0]   POLES_RESET  = 7'd7;
    localparam logic [BASE_W-1:0] BASE_RESET   = 22'd500000;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [1:0] STAT_FIRST    = 2'd0;
    localparam logic [1:0] STAT_UPDATED  = 2'd1;
    localparam logic [1:0] STAT_REJECTED = 2'd2;
    localparam logic [1:0] STAT_CLEARED  = 2'd3;

    // tick length: radius * 2pi in Q40 metres per micrometre, over pole pairs
    localparam int TPQ_W = 23;
    localparam logic [TPQ_W-1:0] TWO_PI_Q40_PER_UM = 23'd6908435;
    localparam int TICK_W     = RAD_W + TPQ_W;
    localparam int DIST_SHIFT = 40 - FRAC_BITS;
    localparam int DACC_W     = 32 + TICK_W;

    // speed: distance * 1000 / gap
    localparam int GAP_W   = $clog2(MAX_GAP_MS + 1);
    localparam int SCALE_W = 10;
    localparam logic [SCALE_W-1:0] MS_PER_S = 10'd1000;
    localparam int SPN_W   = 32 + SCALE_W;

    // heading: |dR-dL| * gain / wheel base
    localparam logic [63:0] BAM_PER_RAD_E6 = 64'd683565275576432;
    localparam logic [63:0] HEAD_GAIN_64   = BAM_PER_RAD_E6 >> FRAC_BITS;
    localparam int GS_W = $clog2(HEAD_GAIN_64 + 64'd1);
    localparam logic [GS_W-1:0] HEAD_GAIN = HEAD_GAIN_64[GS_W-1:0];
    localparam int HP_W = 33 + GS_W;

    // cordic, Q30
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int PM_W = 66;

    localparam int CNT_W = 7;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_DIST,
        S_DSAT,
        S_SPEED,
        S_HMUL,
        S_HDIV,
        S_CSET,
        S_CORDIC,
        S_PSET,
        S_PMUL,
        S_ACC,
        S_OUT
    } state_t;

    // signed wheel distance from the scaled product, saturated
    function automatic logic [31:0] dist_sat(input logic [DACC_W-1:0] acc, input logic neg);
        logic [DACC_W-1:0] r;
        r = acc >> DIST_SHIFT;
        if (neg)
        begin
            if (r > DACC_W'(33'h0_8000_0000))
                return 32'h8000_0000;
            else
                return 32'd0 - r[31:0];
        end
        else
        begin
            if (r > DACC_W'(33'h0_7FFF_FFFF))
                return 32'h7FFF_FFFF;
            else
                return r[31:0];
        end
    endfunction

    // magnitude of the saturated distance
    function automatic logic [31:0] dist_mag(input logic [DACC_W-1:0] acc, input logic neg);
        logic [DACC_W-1:0] r;
        logic [DACC_W-1:0] lim;
        r   = acc >> DIST_SHIFT;
        lim = neg ? DACC_W'(33'h0_8000_0000) : DACC_W'(33'h0_7FFF_FFFF);
        if (r > lim)
            return lim[31:0];
        else
            return r[31:0];
    endfunction

    function automatic logic [31:0] speed_sat(input logic [SPN_W-1:0] q, input logic neg);
        if (neg)
        begin
            if (q > SPN_W'(33'h0_8000_0000))
                return 32'h8000_0000;
            else
                return 32'd0 - q[31:0];
        end
        else
        begin
            if (q > SPN_W'(33'h0_7FFF_FFFF))
                return 32'h7FFF_FFFF;
            else
                return q[31:0];
        end
    endfunction

    // floor of +-p / 2^31
    function automatic logic signed [39:0] scale_step(input logic [PM_W-1:0] p, input logic neg);
        logic [PM_W:0] t;
        if (neg)
        begin
            t = ({1'b0, p} + (PM_W + 1)'(32'h7FFF_FFFF)) >> 31;
            return 40'd0 - t[39:0];
        end
        else
        begin
            t = {1'b0, p} >> 31;
            return t[39:0];
        end
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic signed [39:0] step);
        logic signed [39:0] s;
        s = $signed({{8{a[31]}}, a}) + step;
        if (s > 40'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (s < -40'sd2147483648)
            return 32'h8000_0000;
        else
            return s[31:0];
    endfunction

endpackage

// ----- rtl/diff_drive_odometry.sv -----
// ----------------------------------------------------------------------------
// diff_drive_odometry: differential-drive wheel odometry
// Integrates tach counts into position, heading and wheel speeds.
// ----------------------------------------------------------------------------
// Usage
//   s_* takes one sample per transfer: command in s_tuser, tach counts and
//   timestamp in s_tdata. m_* gives one result per sample with the status in
//   m_tuser. cfg_* writes one register per transfer; write only while idle.
//   A clear command, the first sample and a time-rejected sample go from
//   idle straight to the output step. An accepted sample runs through
//   bit-serial units one bit a cycle: tick division, distance multiply,
//   speed division, heading multiply, heading division, cordic and position
//   multiply, plus 5 single-state steps, the heading divider being the
//   longest step.
//   s_tready is high whenever the sequencer is idle, also while a result is
//   still held on m_*; a new result waits in the last step until the held one
//   is taken, so a stalled receiver only holds up the next sample's finish.
//   Reset clears the odometry state and loads the register defaults.
// ----------------------------------------------------------------------------
module diff_drive_odometry
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [95:0]                 s_tdata,   // left count, right count, time_ms
    input  logic [0:0]                  s_tuser,   // command
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // pos_x, pos_y, heading, speed_left, speed_right, shown left, shown right count
    output logic [223:0]                m_tdata,
    output logic [1:0]                  m_tuser,   // status
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ddo_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ddo_pkg::CFG_W-1:0]   cfg_data
);

    ddo_pkg::state_t state_reg, state_next;
    logic [ddo_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [ddo_pkg::CNT_W-1:0] phase_len;
    logic phase_counted, phase_last, s_fire, out_load;

    // configuration
    logic [ddo_pkg::RAD_W-1:0]  radius_reg;
    logic [ddo_pkg::PP_W-1:0]   poles_reg;
    logic                       left_rev_reg, right_rev_reg;
    logic [ddo_pkg::BASE_W-1:0] base_reg;

    // odometry state
    logic [31:0] prev_left_reg, prev_right_reg, prev_time_reg;
    logic [31:0] shown_left_reg, shown_right_reg;
    logic        started_reg;
    logic [31:0] x_acc_reg, y_acc_reg, angle_acc_reg, vel_left_reg, vel_right_reg;
    logic [1:0]  status_reg;

    // result register
    logic         m_tvalid_reg;
    logic [223:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    // working registers
    logic [31:0]                 tl_reg, tr_reg, now_reg;
    logic [ddo_pkg::GAP_W-1:0]   gap_reg;
    logic                        negl_reg, negr_reg;
    logic [31:0]                 ml_reg, mr_reg;
    logic [ddo_pkg::TICK_W-1:0]  tick_d_reg;
    logic [ddo_pkg::PP_W-1:0]    tick_r_reg;
    logic [ddo_pkg::DACC_W-1:0]  dacc_l_reg, dacc_r_reg;
    logic [31:0]                 dl_reg, dr_reg;
    logic [ddo_pkg::SPN_W-1:0]   spd_dl_reg, spd_dr_reg;
    logic [ddo_pkg::GAP_W-1:0]   spd_rl_reg, spd_rr_reg;
    logic [32:0]                 hm_reg, smag_reg;
    logic                        diff_neg_reg, sum_neg_reg;
    logic [ddo_pkg::HP_W-1:0]    hacc_reg;
    logic [ddo_pkg::BASE_W-1:0]  hrem_reg;
    logic [31:0]                 whole_reg;
    logic                        flip_reg;
    logic signed [ddo_pkg::CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [32:0]                 cxm_reg, cym_reg;
    logic                        cxn_reg, cyn_reg;
    logic [ddo_pkg::PM_W-1:0]    pax_reg, pay_reg;

    // combinational datapath
    logic [31:0] in_tl, in_tr, in_now, gap_full, d_l, d_r;
    logic        in_cmd, reject;
    logic [ddo_pkg::PP_W-1:0]   poles_eff;
    logic [ddo_pkg::BASE_W-1:0] base_eff;
    logic [ddo_pkg::PP_W:0]     tick_t;
    logic                       tick_ge;
    logic [ddo_pkg::TICK_W:0]   dsum_l, dsum_r;
    logic [31:0]                dmag_l, dmag_r;
    logic [ddo_pkg::GAP_W:0]    spd_tl, spd_tr;
    logic                       spd_gel, spd_ger;
    logic [32:0]                sum33, diff33;
    logic [ddo_pkg::GS_W:0]     hsum;
    logic [ddo_pkg::BASE_W:0]   hdiv_t;
    logic                       hdiv_ge;
    logic [31:0]                whole_c, half_c, ang_c;
    logic signed [ddo_pkg::CW-1:0] cdx, cdy, catan, cc, cs;
    logic [33:0]                psum_x, psum_y;

    assign in_cmd = s_tuser[0];
    assign in_tl  = s_tdata[31:0];
    assign in_tr  = s_tdata[63:32];
    assign in_now = s_tdata[95:64];

    always_comb
    begin
        gap_full  = in_now - prev_time_reg;
        reject    = (gap_full == 32'd0) || (gap_full > 32'(ddo_pkg::MAX_GAP_MS));
        d_l       = in_tl - prev_left_reg;
        d_r       = in_tr - prev_right_reg;
        poles_eff = (poles_reg == '0) ? ddo_pkg::PP_W'(1) : poles_reg;
        base_eff  = (base_reg == '0) ? ddo_pkg::BASE_W'(1) : base_reg;

        // restoring divide step for the tick length
        tick_t  = {tick_r_reg, tick_d_reg[ddo_pkg::TICK_W-1]};
        tick_ge = tick_t >= {1'b0, poles_eff};

        // shift-add multiply steps, multiplier bit taken from the lsb
        dsum_l = {1'b0, dacc_l_reg[ddo_pkg::DACC_W-1:32]}
               + (ml_reg[0] ? {1'b0, tick_d_reg} : '0);
        dsum_r = {1'b0, dacc_r_reg[ddo_pkg::DACC_W-1:32]}
               + (mr_reg[0] ? {1'b0, tick_d_reg} : '0);

        dmag_l = ddo_pkg::dist_mag(dacc_l_reg, negl_reg);
        dmag_r = ddo_pkg::dist_mag(dacc_r_reg, negr_reg);

        spd_tl  = {spd_rl_reg, spd_dl_reg[ddo_pkg::SPN_W-1]};
        spd_tr  = {spd_rr_reg, spd_dr_reg[ddo_pkg::SPN_W-1]};
        spd_gel = spd_tl >= {1'b0, gap_reg};
        spd_ger = spd_tr >= {1'b0, gap_reg};

        sum33  = {dl_reg[31], dl_reg} + {dr_reg[31], dr_reg};
        diff33 = {dr_reg[31], dr_reg} - {dl_reg[31], dl_reg};

        hsum = {1'b0, hacc_reg[ddo_pkg::HP_W-1:33]}
             + (hm_reg[0] ? {1'b0, ddo_pkg::HEAD_GAIN} : '0);

        hdiv_t  = {hrem_reg, hacc_reg[ddo_pkg::HP_W-1]};
        hdiv_ge = hdiv_t >= {1'b0, base_eff};

        whole_c = diff_neg_reg ? 32'd0 - hacc_reg[31:0] : hacc_reg[31:0];
        half_c  = diff_neg_reg ? 32'd0 - hacc_reg[32:1] : hacc_reg[32:1];
        ang_c   = angle_acc_reg + half_c;

        cdx   = cy_reg >>> cnt_reg[4:0];
        cdy   = cx_reg >>> cnt_reg[4:0];
        catan = $signed({2'b00, ddo_pkg::ATAN_TAB[cnt_reg[4:0]]});
        cc    = flip_reg ? -cx_reg : cx_reg;
        cs    = flip_reg ? -cy_reg : cy_reg;

        psum_x = {1'b0, pax_reg[ddo_pkg::PM_W-1:33]} + (smag_reg[0] ? {1'b0, cxm_reg} : '0);
        psum_y = {1'b0, pay_reg[ddo_pkg::PM_W-1:33]} + (smag_reg[0] ? {1'b0, cym_reg} : '0);
    end

    // control outputs
    always_comb
    begin
        s_tready  = (state_reg == ddo_pkg::S_IDLE);
        cfg_ready = 1'b1;
        s_fire    = s_tvalid && s_tready;
        out_load  = (state_reg == ddo_pkg::S_OUT) && (!m_tvalid_reg || m_tready);
        case (state_reg)
            ddo_pkg::S_TICK:   phase_len = ddo_pkg::CNT_W'(ddo_pkg::TICK_W);
            ddo_pkg::S_DIST:   phase_len = ddo_pkg::CNT_W'(32);
            ddo_pkg::S_SPEED:  phase_len = ddo_pkg::CNT_W'(ddo_pkg::SPN_W);
            ddo_pkg::S_HMUL:   phase_len = ddo_pkg::CNT_W'(33);
            ddo_pkg::S_HDIV:   phase_len = ddo_pkg::CNT_W'(ddo_pkg::HP_W);
            ddo_pkg::S_CORDIC: phase_len = ddo_pkg::CNT_W'(ddo_pkg::TRIG_ITERATIONS);
            ddo_pkg::S_PMUL:   phase_len = ddo_pkg::CNT_W'(33);
            default:           phase_len = ddo_pkg::CNT_W'(1);
        endcase
        phase_counted = (state_reg == ddo_pkg::S_TICK) || (state_reg == ddo_pkg::S_DIST)
                     || (state_reg == ddo_pkg::S_SPEED) || (state_reg == ddo_pkg::S_HMUL)
                     || (state_reg == ddo_pkg::S_HDIV) || (state_reg == ddo_pkg::S_CORDIC)
                     || (state_reg == ddo_pkg::S_PMUL);
        phase_last = (cnt_reg == phase_len - ddo_pkg::CNT_W'(1));
        cnt_next   = (phase_counted && !phase_last) ? cnt_reg + ddo_pkg::CNT_W'(1) : '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ddo_pkg::S_IDLE:
            begin
                if (s_fire)
                begin
                    if (in_cmd == ddo_pkg::CMD_CLEAR || !started_reg || reject)
                        state_next = ddo_pkg::S_OUT;
                    else
                        state_next = ddo_pkg::S_TICK;
                end
            end
            ddo_pkg::S_TICK:   if (phase_last) state_next = ddo_pkg::S_DIST;
            ddo_pkg::S_DIST:   if (phase_last) state_next = ddo_pkg::S_DSAT;
            ddo_pkg::S_DSAT:   state_next = ddo_pkg::S_SPEED;
            ddo_pkg::S_SPEED:  if (phase_last) state_next = ddo_pkg::S_HMUL;
            ddo_pkg::S_HMUL:   if (phase_last) state_next = ddo_pkg::S_HDIV;
            ddo_pkg::S_HDIV:   if (phase_last) state_next = ddo_pkg::S_CSET;
            ddo_pkg::S_CSET:   state_next = ddo_pkg::S_CORDIC;
            ddo_pkg::S_CORDIC: if (phase_last) state_next = ddo_pkg::S_PSET;
            ddo_pkg::S_PSET:   state_next = ddo_pkg::S_PMUL;
            ddo_pkg::S_PMUL:   if (phase_last) state_next = ddo_pkg::S_ACC;
            ddo_pkg::S_ACC:    state_next = ddo_pkg::S_OUT;
            ddo_pkg::S_OUT:    if (out_load) state_next = ddo_pkg::S_IDLE;
            default:           state_next = ddo_pkg::S_IDLE;
        endcase
    end

    // control, configuration and odometry state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ddo_pkg::S_IDLE;
            cnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            radius_reg      <= ddo_pkg::RADIUS_RESET;
            poles_reg       <= ddo_pkg::POLES_RESET;
            left_rev_reg    <= 1'b0;
            right_rev_reg   <= 1'b0;
            base_reg        <= ddo_pkg::BASE_RESET;
            prev_left_reg   <= '0;
            prev_right_reg  <= '0;
            prev_time_reg   <= '0;
            shown_left_reg  <= '0;
            shown_right_reg <= '0;
            started_reg     <= 1'b0;
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            angle_acc_reg   <= '0;
            vel_left_reg    <= '0;
            vel_right_reg   <= '0;
            status_reg      <= ddo_pkg::STAT_CLEARED;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ddo_pkg::REG_WHEEL_RADIUS: radius_reg    <= cfg_data[ddo_pkg::RAD_W-1:0];
                    ddo_pkg::REG_POLE_PAIRS:   poles_reg     <= cfg_data[ddo_pkg::PP_W-1:0];
                    ddo_pkg::REG_LEFT_REV:     left_rev_reg  <= cfg_data[0];
                    ddo_pkg::REG_RIGHT_REV:    right_rev_reg <= cfg_data[0];
                    ddo_pkg::REG_WHEEL_BASE:   base_reg      <= cfg_data[ddo_pkg::BASE_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ddo_pkg::S_IDLE:
                begin
                    if (s_fire)
                    begin
                        if (in_cmd == ddo_pkg::CMD_CLEAR)
                        begin
                            prev_left_reg   <= '0;
                            prev_right_reg  <= '0;
                            prev_time_reg   <= '0;
                            shown_left_reg  <= '0;
                            shown_right_reg <= '0;
                            started_reg     <= 1'b0;
                            x_acc_reg       <= '0;
                            y_acc_reg       <= '0;
                            angle_acc_reg   <= '0;
                            vel_left_reg    <= '0;
                            vel_right_reg   <= '0;
                            status_reg      <= ddo_pkg::STAT_CLEARED;
                        end
                        else if (!started_reg)
                        begin
                            prev_left_reg   <= in_tl;
                            prev_right_reg  <= in_tr;
                            shown_left_reg  <= in_tl;
                            shown_right_reg <= in_tr;
                            prev_time_reg   <= in_now;
                            started_reg     <= 1'b1;
                            status_reg      <= ddo_pkg::STAT_FIRST;
                        end
                        else if (reject)
                        begin
                            // tach deltas carry over to the next good sample
                            prev_time_reg <= in_now;
                            status_reg    <= ddo_pkg::STAT_REJECTED;
                        end
                    end
                end
                ddo_pkg::S_CSET:
                begin
                    vel_left_reg  <= ddo_pkg::speed_sat(spd_dl_reg, dl_reg[31]);
                    vel_right_reg <= ddo_pkg::speed_sat(spd_dr_reg, dr_reg[31]);
                end
                ddo_pkg::S_ACC:
                begin
                    x_acc_reg <= ddo_pkg::sat_add(x_acc_reg,
                                     ddo_pkg::scale_step(pax_reg, sum_neg_reg ^ cxn_reg));
                    y_acc_reg <= ddo_pkg::sat_add(y_acc_reg,
                                     ddo_pkg::scale_step(pay_reg, sum_neg_reg ^ cyn_reg));
                    angle_acc_reg   <= angle_acc_reg + whole_reg;
                    prev_left_reg   <= tl_reg;
                    prev_right_reg  <= tr_reg;
                    shown_left_reg  <= tl_reg;
                    shown_right_reg <= tr_reg;
                    prev_time_reg   <= now_reg;
                    status_reg      <= ddo_pkg::STAT_UPDATED;
                end
                default: ;
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {shown_right_reg, shown_left_reg, vel_right_reg, vel_left_reg,
                            angle_acc_reg, y_acc_reg, x_acc_reg};
            m_tuser_reg <= status_reg;
        end
    end

    // bit-serial working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ddo_pkg::S_IDLE:
            begin
                if (s_fire)
                begin
                    tl_reg     <= in_tl;
                    tr_reg     <= in_tr;
                    now_reg    <= in_now;
                    gap_reg    <= gap_full[ddo_pkg::GAP_W-1:0];
                    negl_reg   <= d_l[31] ^ left_rev_reg;
                    negr_reg   <= d_r[31] ^ right_rev_reg;
                    ml_reg     <= d_l[31] ? 32'd0 - d_l : d_l;
                    mr_reg     <= d_r[31] ? 32'd0 - d_r : d_r;
                    tick_d_reg <= ddo_pkg::TICK_W'(radius_reg)
                                * ddo_pkg::TICK_W'(ddo_pkg::TWO_PI_Q40_PER_UM);
                    tick_r_reg <= '0;
                end
            end
            ddo_pkg::S_TICK:
            begin
                tick_r_reg <= tick_ge ? ddo_pkg::PP_W'(tick_t - {1'b0, poles_eff})
                                      : tick_t[ddo_pkg::PP_W-1:0];
                tick_d_reg <= {tick_d_reg[ddo_pkg::TICK_W-2:0], tick_ge};
                if (phase_last)
                begin
                    dacc_l_reg <= '0;
                    dacc_r_reg <= '0;
                end
            end
            ddo_pkg::S_DIST:
            begin
                ml_reg     <= ml_reg >> 1;
                mr_reg     <= mr_reg >> 1;
                dacc_l_reg <= {dsum_l, dacc_l_reg[31:1]};
                dacc_r_reg <= {dsum_r, dacc_r_reg[31:1]};
            end
            ddo_pkg::S_DSAT:
            begin
                dl_reg     <= ddo_pkg::dist_sat(dacc_l_reg, negl_reg);
                dr_reg     <= ddo_pkg::dist_sat(dacc_r_reg, negr_reg);
                spd_dl_reg <= ddo_pkg::SPN_W'(dmag_l) * ddo_pkg::SPN_W'(ddo_pkg::MS_PER_S);
                spd_dr_reg <= ddo_pkg::SPN_W'(dmag_r) * ddo_pkg::SPN_W'(ddo_pkg::MS_PER_S);
                spd_rl_reg <= '0;
                spd_rr_reg <= '0;
            end
            ddo_pkg::S_SPEED:
            begin
                spd_rl_reg <= spd_gel ? ddo_pkg::GAP_W'(spd_tl - {1'b0, gap_reg})
                                      : spd_tl[ddo_pkg::GAP_W-1:0];
                spd_rr_reg <= spd_ger ? ddo_pkg::GAP_W'(spd_tr - {1'b0, gap_reg})
                                      : spd_tr[ddo_pkg::GAP_W-1:0];
                spd_dl_reg <= {spd_dl_reg[ddo_pkg::SPN_W-2:0], spd_gel};
                spd_dr_reg <= {spd_dr_reg[ddo_pkg::SPN_W-2:0], spd_ger};
                if (phase_last)
                begin
                    diff_neg_reg <= diff33[32];
                    sum_neg_reg  <= sum33[32];
                    hm_reg       <= diff33[32] ? 33'd0 - diff33 : diff33;
                    smag_reg     <= sum33[32] ? 33'd0 - sum33 : sum33;
                    hacc_reg     <= '0;
                end
            end
            ddo_pkg::S_HMUL:
            begin
                hm_reg   <= hm_reg >> 1;
                hacc_reg <= {hsum, hacc_reg[32:1]};
                if (phase_last)
                    hrem_reg <= '0;
            end
            ddo_pkg::S_HDIV:
            begin
                hrem_reg <= hdiv_ge ? ddo_pkg::BASE_W'(hdiv_t - {1'b0, base_eff})
                                    : hdiv_t[ddo_pkg::BASE_W-1:0];
                hacc_reg <= {hacc_reg[ddo_pkg::HP_W-2:0], hdiv_ge};
            end
            ddo_pkg::S_CSET:
            begin
                // fold the second and third quadrants onto the other half
                whole_reg <= whole_c;
                flip_reg  <= (ang_c[31:30] == 2'd1) || (ang_c[31:30] == 2'd2);
                cz_reg    <= ((ang_c[31:30] == 2'd1) || (ang_c[31:30] == 2'd2))
                           ? $signed({{2{~ang_c[31]}}, ~ang_c[31], ang_c[30:0]})
                           : $signed({{2{ang_c[31]}}, ang_c});
                cx_reg    <= ddo_pkg::CORDIC_GAIN;
                cy_reg    <= '0;
            end
            ddo_pkg::S_CORDIC:
            begin
                if (!cz_reg[ddo_pkg::CW-1])
                begin
                    cx_reg <= cx_reg - cdx;
                    cy_reg <= cy_reg + cdy;
                    cz_reg <= cz_reg - catan;
                end
                else
                begin
                    cx_reg <= cx_reg + cdx;
                    cy_reg <= cy_reg - cdy;
                    cz_reg <= cz_reg + catan;
                end
            end
            ddo_pkg::S_PSET:
            begin
                cxn_reg <= cc[ddo_pkg::CW-1];
                cyn_reg <= cs[ddo_pkg::CW-1];
                cxm_reg <= cc[ddo_pkg::CW-1] ? 33'(-cc) : 33'(cc);
                cym_reg <= cs[ddo_pkg::CW-1] ? 33'(-cs) : 33'(cs);
                pax_reg <= '0;
                pay_reg <= '0;
            end
            ddo_pkg::S_PMUL:
            begin
                smag_reg <= smag_reg >> 1;
                pax_reg  <= {psum_x, pax_reg[32:1]};
                pay_reg  <= {psum_y, pay_reg[32:1]};
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a result finishing with the output free is shown in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid)
        else $error("finished result not presented");

    // the step counter never runs past the length of its phase
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_counted |-> (cnt_reg < phase_len))
        else $error("step counter overran its phase");

    // a clear command leaves the odometry empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && in_cmd == ddo_pkg::CMD_CLEAR) |=>
        (!started_reg && x_acc_reg == '0 && y_acc_reg == '0 && angle_acc_reg == '0))
        else $error("clear command left state behind");

    // only a clear command drops the started flag
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(started_reg) |-> $past(s_fire && in_cmd == ddo_pkg::CMD_CLEAR))
        else $error("started flag dropped without a clear");

    // a full update only runs once the first sample has been latched
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ddo_pkg::S_TICK) |-> started_reg)
        else $error("update started before first sample");

endmodule
